@@ hdl/crm_pkg.sv @@
`default_nettype none

package crm_pkg;

  // One key event as it arrives
  typedef struct packed {
    logic [7:0] scan_code;
    logic       is_release;
    logic [1:0] ext_flags;
  } crm_in_t;

  // One forwarded event
  typedef struct packed {
    logic [7:0] out_scan_code;
    logic       out_is_release;
    logic [1:0] out_ext_flags;
    logic       last;
  } crm_out_t;

  // What one event produces: zero, one or two beats
  typedef struct packed {
    logic [1:0] count;
    crm_out_t   beat0;
    crm_out_t   beat1;
  } crm_res_t;

  localparam int unsigned ChordTableSize = 29;

  // Chord keys, left hand
  localparam logic [7:0] KeyA = 8'h1e;
  localparam logic [7:0] KeyS = 8'h1f;
  localparam logic [7:0] KeyD = 8'h20;
  localparam logic [7:0] KeyF = 8'h21;
  // Chord keys, right hand
  localparam logic [7:0] KeyH     = 8'h23;
  localparam logic [7:0] KeyJ     = 8'h24;
  localparam logic [7:0] KeyK     = 8'h25;
  localparam logic [7:0] KeyL     = 8'h26;
  localparam logic [7:0] KeySpace = 8'h39;

  // Left-hand index of a scan code, zero if not a left chord key
  function automatic logic [2:0] left_key(input logic [7:0] code);
    logic [2:0] idx;
    unique case (code)
      KeyA:    idx = 3'd1;
      KeyS:    idx = 3'd2;
      KeyD:    idx = 3'd3;
      KeyF:    idx = 3'd4;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Right-hand index of a scan code, zero if not a right chord key
  function automatic logic [2:0] right_key(input logic [7:0] code);
    logic [2:0] idx;
    unique case (code)
      KeyH:     idx = 3'd1;
      KeyJ:     idx = 3'd2;
      KeyK:     idx = 3'd3;
      KeyL:     idx = 3'd4;
      KeySpace: idx = 3'd5;
      default:  idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Chord translation table, index = left + 5*right - 1
  function automatic logic [7:0] chord_code(input logic [4:0] idx);
    logic [7:0] code;
    unique case (idx)
      5'd0:  code = 8'h1e;
      5'd1:  code = 8'h1f;
      5'd2:  code = 8'h20;
      5'd3:  code = 8'h21;
      5'd4:  code = 8'h23;
      5'd5:  code = 8'h11;
      5'd6:  code = 8'h2d;
      5'd7:  code = 8'h12;
      5'd8:  code = 8'h2e;
      5'd9:  code = 8'h24;
      5'd10: code = 8'h13;
      5'd11: code = 8'h2f;
      5'd12: code = 8'h14;
      5'd13: code = 8'h30;
      5'd14: code = 8'h25;
      5'd15: code = 8'h15;
      5'd16: code = 8'h31;
      5'd17: code = 8'h16;
      5'd18: code = 8'h32;
      5'd19: code = 8'h26;
      5'd20: code = 8'h22;
      5'd21: code = 8'h17;
      5'd22: code = 8'h18;
      5'd23: code = 8'h19;
      5'd24: code = 8'h39;
      5'd25: code = 8'h10;
      5'd26: code = 8'h2c;
      5'd27: code = 8'h33;
      5'd28: code = 8'h34;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crm_core.sv @@
`default_nettype none

module crm_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire crm_pkg::crm_in_t item,
  output crm_pkg::crm_res_t    res
);

  logic [2:0] left_r, left_nxt;
  logic [2:0] right_r, right_nxt;
  logic       pending_r, pending_nxt;

  logic [2:0] kl, kr;
  logic [5:0] sum;
  logic [4:0] idx;
  logic       hit;
  logic [7:0] xcode;

  // Key decode and chord translation
  always_comb begin
    kl    = crm_pkg::left_key(item.scan_code);
    kr    = crm_pkg::right_key(item.scan_code);
    sum   = {3'b000, left_r} + {1'b0, right_r, 2'b00} + {3'b000, right_r};
    idx   = 5'(sum - 6'd1);
    hit   = (sum >= 6'd1) && (sum <= 6'(crm_pkg::ChordTableSize));
    xcode = hit ? crm_pkg::chord_code(idx) : item.scan_code;
  end

  // Result beats
  always_comb begin
    res.count = 2'd0;
    res.beat0 = '{out_scan_code: item.scan_code, out_is_release: item.is_release,
                  out_ext_flags: item.ext_flags, last: 1'b1};
    res.beat1 = '{out_scan_code: xcode, out_is_release: 1'b1,
                  out_ext_flags: item.ext_flags, last: 1'b1};
    if (!item.is_release) begin
      res.count = (kl == 3'd0 && kr == 3'd0) ? 2'd1 : 2'd0;
    end else if (pending_r) begin
      res.count = 2'd2;
      res.beat0 = '{out_scan_code: xcode, out_is_release: 1'b0,
                    out_ext_flags: item.ext_flags, last: 1'b0};
    end else begin
      res.count = 2'd1;
    end
  end

  // Chord state update
  always_comb begin
    left_nxt    = left_r;
    right_nxt   = right_r;
    pending_nxt = pending_r;
    if (fire) begin
      if (!item.is_release) begin
        if (kl != 3'd0) left_nxt = kl;
        if (kr != 3'd0) right_nxt = kr;
        if (kl != 3'd0 || kr != 3'd0) pending_nxt = 1'b1;
      end else begin
        pending_nxt = 1'b0;
        if (kl != 3'd0) left_nxt = 3'd0;
        if (kr != 3'd0) right_nxt = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r    <= 3'd0;
      right_r   <= 3'd0;
      pending_r <= 1'b0;
    end else begin
      left_r    <= left_nxt;
      right_r   <= right_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/chord_keyboard_remapper.sv @@
// Chord keyboard remapper.
// Input channel (in_valid/in_ready/in_data) takes one key event per beat.
// Output channel (out_valid/out_ready/out_data) gives the forwarded events;
// out_data.last marks the final beat caused by one input event.
// A chord key press gives no beat, any other press or a plain release gives
// one, and a release while a chord is pending gives two (make, then break of
// the translated code).
// An event is captured in the input register, then translated into a
// two-entry output buffer; out_valid is high while the buffer is not empty.
// Throughput: one event per cycle when it gives at most one beat and the
// receiver does not stall; a chord release puts two beats through the
// single output port.
// When the receiver stalls the output buffer fills, then the input register
// holds, and in_ready drops; nothing is lost.
// Reset (synchronous, rst_n low) empties both stages and clears the held
// chord keys and the pending flag.
`default_nettype none

module chord_keyboard_remapper (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire crm_pkg::crm_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output crm_pkg::crm_out_t      out_data
);

  // Input register
  logic              s1_v_r, s1_v_nxt;
  crm_pkg::crm_in_t  s1_r;
  logic              go;
  crm_pkg::crm_res_t res;

  // Output buffer
  crm_pkg::crm_out_t slot0_r, slot0_nxt;
  crm_pkg::crm_out_t slot1_r, slot1_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [1:0]        cnt_left;
  logic              pop;

  crm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (go),
    .item  (s1_r),
    .res   (res)
  );

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign cnt_left  = cnt_r - {1'b0, pop};
  assign go        = s1_v_r && ({1'b0, cnt_left} + {1'b0, res.count} <= 3'd2);
  assign in_ready  = !s1_v_r || go;
  assign s1_v_nxt  = (in_valid && in_ready) || (s1_v_r && !go);

  // Shift out the head beat, then append the new beats
  always_comb begin
    slot0_nxt = pop ? slot1_r : slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_left;
    if (go) begin
      cnt_nxt = cnt_left + res.count;
      if (res.count == 2'd2) begin
        slot0_nxt = res.beat0;
        slot1_nxt = res.beat1;
      end else if (res.count == 2'd1) begin
        if (cnt_left == 2'd0) begin
          slot0_nxt = res.beat0;
        end else begin
          slot1_nxt = res.beat0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      s1_v_r <= s1_v_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_r <= in_data;
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

`default_nettype wire

@@ hdl/crm_checker.sv @@
`default_nettype none

module crm_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire crm_pkg::crm_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire crm_pkg::crm_out_t out_data
);

  // A waiting input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while waiting");

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // Only the make of a chord pair is a non-final beat
  a_first_is_make: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> !out_data.out_is_release)
    else $error("non-final beat is not a make");

  // The break follows the make at once, with the same code and flags
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && out_data.out_is_release && out_data.last &&
      out_data.out_scan_code == $past(out_data.out_scan_code) &&
      out_data.out_ext_flags == $past(out_data.out_ext_flags))
    else $error("chord break beat missing or mismatched");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind chord_keyboard_remapper crm_checker u_crm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
